// ===== rtl/core/qppe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree polynomial evaluator package
// Shared types, codes and default sizes for the controller and datapath.
// ----------------------------------------------------------------------------
package qppe_pkg;

  localparam int NODE_COUNT_DEF  = 128;
  localparam int LEAF_COUNT_DEF  = 128;
  localparam int COEFF_COUNT_DEF = 1024;
  localparam int MAX_DEGREE_DEF  = 7;
  localparam int MAX_DEPTH_DEF   = 16;

  typedef enum logic [2:0] {
    ACT_NODE  = 3'd0,
    ACT_CHILD = 3'd1,
    ACT_LEAF  = 3'd2,
    ACT_COEF  = 3'd3,
    ACT_EVAL  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEPTH = 2'd1,
    ST_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_NODE, S_CHILD, S_LEAF, S_CREAD, S_C0,
    S_MONO, S_PUSH, S_TERM, S_LAST, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_ROOT, OP_DESC, OP_LEAF, OP_CHILD, OP_CBASE,
    OP_C0, OP_MONO, OP_PUSH, OP_TERM, OP_LAST, OP_OUT
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    load;
    logic    err_set;
    status_t err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic code_neg;
    logic depth_hit;
    logic internal_bad;
    logic node_bad;
    logic leaf_bad;
    logic rec_bad;
    logic deg_zero;
    logic last_term;
  } dp_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/qppe_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree polynomial evaluator controller
// Sequences tree descent, leaf checks and the multiply-accumulate loop.
// ----------------------------------------------------------------------------
module qppe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          action,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire qppe_pkg::dp_flags_t flags,
  output qppe_pkg::dp_cmd_t        cmd
);

  qppe_pkg::state_t state, state_next;
  logic accept_in;
  logic is_eval;

  assign in_stall  = (state != qppe_pkg::S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign is_eval   = (action == qppe_pkg::ACT_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qppe_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == qppe_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qppe_pkg::S_IDLE: begin
        if (accept_in && is_eval) state_next = qppe_pkg::S_ROOT;
      end
      qppe_pkg::S_ROOT: state_next = qppe_pkg::S_NODE;
      qppe_pkg::S_NODE: begin
        if (flags.code_neg) begin
          if (flags.depth_hit || flags.internal_bad) state_next = qppe_pkg::S_DONE;
          else state_next = qppe_pkg::S_CHILD;
        end else begin
          if (flags.leaf_bad) state_next = qppe_pkg::S_DONE;
          else state_next = qppe_pkg::S_LEAF;
        end
      end
      qppe_pkg::S_CHILD: begin
        if (flags.node_bad) state_next = qppe_pkg::S_DONE;
        else state_next = qppe_pkg::S_NODE;
      end
      qppe_pkg::S_LEAF: begin
        if (flags.rec_bad) state_next = qppe_pkg::S_DONE;
        else state_next = qppe_pkg::S_CREAD;
      end
      qppe_pkg::S_CREAD: state_next = qppe_pkg::S_C0;
      qppe_pkg::S_C0: begin
        if (flags.deg_zero) state_next = qppe_pkg::S_DONE;
        else state_next = qppe_pkg::S_MONO;
      end
      qppe_pkg::S_MONO: state_next = qppe_pkg::S_PUSH;
      qppe_pkg::S_PUSH: state_next = qppe_pkg::S_TERM;
      qppe_pkg::S_TERM: begin
        if (flags.last_term) state_next = qppe_pkg::S_LAST;
        else state_next = qppe_pkg::S_MONO;
      end
      qppe_pkg::S_LAST: state_next = qppe_pkg::S_DONE;
      qppe_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = qppe_pkg::S_IDLE;
      end
      default: state_next = qppe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = qppe_pkg::OP_NONE;
    cmd.load     = 1'b0;
    cmd.err_set  = 1'b0;
    cmd.err_code = qppe_pkg::ST_OK;
    unique case (state)
      qppe_pkg::S_IDLE: begin
        if (accept_in) begin
          if (is_eval) cmd.op = qppe_pkg::OP_START;
          else cmd.load = 1'b1;
        end
      end
      qppe_pkg::S_ROOT: cmd.op = qppe_pkg::OP_ROOT;
      qppe_pkg::S_NODE: begin
        if (flags.code_neg) begin
          if (flags.depth_hit) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = qppe_pkg::ST_DEPTH;
          end else if (flags.internal_bad) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = qppe_pkg::ST_INDEX;
          end else begin
            cmd.op = qppe_pkg::OP_DESC;
          end
        end else if (flags.leaf_bad) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = qppe_pkg::ST_INDEX;
        end else begin
          cmd.op = qppe_pkg::OP_LEAF;
        end
      end
      qppe_pkg::S_CHILD: begin
        if (flags.node_bad) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = qppe_pkg::ST_INDEX;
        end else begin
          cmd.op = qppe_pkg::OP_CHILD;
        end
      end
      qppe_pkg::S_LEAF: begin
        if (flags.rec_bad) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = qppe_pkg::ST_INDEX;
        end else begin
          cmd.op = qppe_pkg::OP_CBASE;
        end
      end
      qppe_pkg::S_CREAD: cmd.op = qppe_pkg::OP_NONE;
      qppe_pkg::S_C0:    cmd.op = qppe_pkg::OP_C0;
      qppe_pkg::S_MONO:  cmd.op = qppe_pkg::OP_MONO;
      qppe_pkg::S_PUSH:  cmd.op = qppe_pkg::OP_PUSH;
      qppe_pkg::S_TERM:  cmd.op = qppe_pkg::OP_TERM;
      qppe_pkg::S_LAST:  cmd.op = qppe_pkg::OP_LAST;
      qppe_pkg::S_DONE: begin
        if (!out_valid || !out_stall) cmd.op = qppe_pkg::OP_OUT;
      end
      default: cmd.op = qppe_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/qppe_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree polynomial evaluator datapath
// Tree tables, box halving, monomial row and the shared multiplier.
// ----------------------------------------------------------------------------
module qppe_dp #(
  parameter int NODE_COUNT  = qppe_pkg::NODE_COUNT_DEF,
  parameter int LEAF_COUNT  = qppe_pkg::LEAF_COUNT_DEF,
  parameter int COEFF_COUNT = qppe_pkg::COEFF_COUNT_DEF,
  parameter int MAX_DEGREE  = qppe_pkg::MAX_DEGREE_DEF,
  parameter int MAX_DEPTH   = qppe_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [2:0]          action,
  input  wire logic [9:0]          table_index,
  input  wire logic signed [7:0]   node_code,
  input  wire logic [6:0]          child_base,
  input  wire logic [2:0]          leaf_degree,
  input  wire logic [9:0]          coeff_base,
  input  wire logic signed [31:0]  coeff_value,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire qppe_pkg::dp_cmd_t   cmd,
  output qppe_pkg::dp_flags_t      flags,
  output logic signed [31:0]       value,
  output logic [6:0]               leaf_number,
  output logic [1:0]               status
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int LW  = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
  localparam int CW  = (COEFF_COUNT > 1) ? $clog2(COEFF_COUNT) : 1;
  localparam int CAW = (CW > 11) ? CW : 11;
  localparam int RN  = MAX_DEGREE + 2;
  localparam int RIW = $clog2(RN);
  localparam int DW  = $clog2(MAX_DEPTH + 1);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [5:0] tri_count(input logic [2:0] deg);
    logic [6:0] p;
    p = ({4'b0, deg} + 7'd1) * ({4'b0, deg} + 7'd2);
    return p[6:1];
  endfunction

  logic signed [31:0] x_low, x_high, y_low, y_high;
  logic signed [31:0] xl, xh, yl, yh, px, py;
  logic [DW-1:0]      levels;
  logic [1:0]         son_q;
  logic [7:0]         code_q;
  logic [6:0]         cb_q;
  logic [12:0]        rec_q;
  logic [6:0]         leaf_q;
  logic signed [31:0] coef_q;
  logic [CAW-1:0]     coef_addr;
  logic [2:0]         k, n;
  logic signed [31:0] row [RN];
  logic [RIW:0]       cnt;
  logic signed [31:0] mono_q;
  logic signed [63:0] prod;
  logic signed [31:0] acc;
  logic               term_pend;
  qppe_pkg::status_t  status_q;

  logic [7:0]         node_mem  [NODE_COUNT];
  logic [6:0]         child_mem [NODE_COUNT];
  logic [12:0]        leaf_mem  [LEAF_COUNT];
  logic signed [31:0] coef_mem  [COEFF_COUNT];

  logic [8:0]         internal;
  logic [7:0]         node_next;
  logic [10:0]        node_raddr;
  logic signed [32:0] xsum, ysum;
  logic signed [31:0] mx, my;
  logic               go_right, go_up;
  logic [2:0]         rec_deg;
  logic [9:0]         rec_base;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] sh;
  logic signed [31:0] sh_sat;
  logic signed [48:0] acc_sum;
  logic               ld_ok_node, ld_ok_leaf, ld_ok_coef;

  assign internal   = 9'd0 - {code_q[7], code_q};
  assign node_next  = {1'b0, cb_q} + {6'b0, son_q};
  assign node_raddr = (cmd.op == qppe_pkg::OP_ROOT) ? 11'd0 : {3'b0, node_next};
  assign xsum       = {xl[31], xl} + {xh[31], xh};
  assign ysum       = {yl[31], yl} + {yh[31], yh};
  assign mx         = xsum[32:1];
  assign my         = ysum[32:1];
  assign go_right   = (px > mx);
  assign go_up      = (py > my);
  assign rec_deg    = rec_q[12:10];
  assign rec_base   = rec_q[9:0];
  assign mul_a      = (cmd.op == qppe_pkg::OP_TERM) ? coef_q : row[0];
  assign mul_b      = (cmd.op == qppe_pkg::OP_TERM) ? mono_q : ((n == 3'd0) ? px : py);
  assign sh         = prod[63:16];
  assign sh_sat     = sat32({sh[47], sh});
  assign acc_sum    = {{17{acc[31]}}, acc} + {sh[47], sh};
  assign ld_ok_node = ({1'b0, table_index} < 11'(NODE_COUNT));
  assign ld_ok_leaf = ({1'b0, table_index} < 11'(LEAF_COUNT));
  assign ld_ok_coef = ({7'b0, table_index} < 17'(COEFF_COUNT));

  assign flags.code_neg     = code_q[7];
  assign flags.depth_hit    = (levels >= DW'(MAX_DEPTH));
  assign flags.internal_bad = ({2'b0, internal} >= 11'(NODE_COUNT));
  assign flags.node_bad     = ({3'b0, node_next} >= 11'(NODE_COUNT));
  assign flags.leaf_bad     = ({4'b0, code_q[6:0]} >= 11'(LEAF_COUNT));
  assign flags.rec_bad      = ({2'b0, rec_deg} > 5'(MAX_DEGREE)) ||
                              (17'(rec_base) + 17'(tri_count(rec_deg)) > 17'(COEFF_COUNT));
  assign flags.deg_zero     = (rec_deg == 3'd0);
  assign flags.last_term    = (n == k) && (k == rec_deg);

  always_ff @(posedge clk) begin
    if (cmd.load && action == qppe_pkg::ACT_NODE && ld_ok_node) begin
      node_mem[NW'(table_index)] <= node_code;
    end
    if (cmd.op == qppe_pkg::OP_ROOT || cmd.op == qppe_pkg::OP_CHILD) begin
      code_q <= node_mem[node_raddr[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action == qppe_pkg::ACT_CHILD && ld_ok_node) begin
      child_mem[NW'(table_index)] <= child_base;
    end
    if (cmd.op == qppe_pkg::OP_DESC) begin
      cb_q <= child_mem[internal[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action == qppe_pkg::ACT_LEAF && ld_ok_leaf) begin
      leaf_mem[LW'(table_index)] <= {leaf_degree, coeff_base};
    end
    if (cmd.op == qppe_pkg::OP_LEAF) begin
      rec_q <= leaf_mem[LW'(code_q[6:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action == qppe_pkg::ACT_COEF && ld_ok_coef) begin
      coef_mem[CW'(table_index)] <= coeff_value;
    end
    coef_q <= coef_mem[coef_addr[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= -32'sd65536;
      x_high <= 32'sd65536;
      y_low  <= -32'sd65536;
      y_high <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (qppe_pkg::reg_t'(cfg_index))
        qppe_pkg::REG_X_LOW:  x_low  <= cfg_data;
        qppe_pkg::REG_X_HIGH: x_high <= cfg_data;
        qppe_pkg::REG_Y_LOW:  y_low  <= cfg_data;
        qppe_pkg::REG_Y_HIGH: y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels    <= '0;
      cnt       <= '0;
      term_pend <= 1'b0;
      status_q  <= qppe_pkg::ST_OK;
    end else begin
      if (cmd.err_set) status_q <= cmd.err_code;
      case (cmd.op)
        qppe_pkg::OP_START: begin
          xl       <= x_low;
          xh       <= x_high;
          yl       <= y_low;
          yh       <= y_high;
          px       <= point_x;
          py       <= point_y;
          levels   <= '0;
          status_q <= qppe_pkg::ST_OK;
        end
        qppe_pkg::OP_DESC: begin
          son_q <= {go_up, go_right};
          if (go_right) xl <= mx; else xh <= mx;
          if (go_up) yl <= my; else yh <= my;
        end
        qppe_pkg::OP_CHILD: levels <= levels + DW'(1);
        qppe_pkg::OP_LEAF:  leaf_q <= code_q[6:0];
        qppe_pkg::OP_CBASE: coef_addr <= CAW'(rec_base);
        qppe_pkg::OP_C0: begin
          acc       <= coef_q;
          coef_addr <= coef_addr + CAW'(1);
          k         <= 3'd1;
          n         <= 3'd0;
          row[0]    <= 32'sh00010000;
          cnt       <= (RIW+1)'(1);
          term_pend <= 1'b0;
        end
        qppe_pkg::OP_MONO: begin
          prod <= mul_a * mul_b;
          if (n != 3'd0) begin
            for (int i = 0; i < RN - 1; i++) row[i] <= row[i+1];
            cnt <= cnt - (RIW+1)'(1);
          end
          if (term_pend) begin
            acc       <= sat32(acc_sum);
            term_pend <= 1'b0;
          end
        end
        qppe_pkg::OP_PUSH: begin
          row[cnt[RIW-1:0]] <= sh_sat;
          cnt               <= cnt + (RIW+1)'(1);
          mono_q            <= sh_sat;
        end
        qppe_pkg::OP_TERM: begin
          prod      <= mul_a * mul_b;
          term_pend <= 1'b1;
          coef_addr <= coef_addr + CAW'(1);
          if (n == k) begin
            k <= k + 3'd1;
            n <= 3'd0;
          end else begin
            n <= n + 3'd1;
          end
        end
        qppe_pkg::OP_LAST: begin
          acc       <= sat32(acc_sum);
          term_pend <= 1'b0;
        end
        qppe_pkg::OP_OUT: begin
          status <= status_q;
          if (status_q == qppe_pkg::ST_OK) begin
            value       <= acc;
            leaf_number <= leaf_q;
          end else begin
            value       <= '0;
            leaf_number <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/quadtree_piecewise_poly_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree piecewise polynomial evaluator
// Loads quadtree tables and evaluates the leaf polynomial at a point.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | action, table_index, node_code,
//         |           |                     | child_base, leaf_degree, coeff_base,
//         |           |                     | coeff_value, point_x, point_y
// out     | output    | out_valid/out_stall | value, leaf_number, status
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A load item never stalls the input, so load items are taken back to back. An evaluate
// item descends the tree, reading the node and child tables at each level, then runs
// each term beyond the constant one through the single shared 32 x 32 multiplier in
// the monomial, push and term steps.
// Reset is synchronous and restores the default rectangle; the tables keep
// their contents. A stalled result is held in the output register, and the
// input stays stalled only while an evaluation is in progress.
// ----------------------------------------------------------------------------
module quadtree_piecewise_poly_eval #(
  parameter int NODE_COUNT  = qppe_pkg::NODE_COUNT_DEF,
  parameter int LEAF_COUNT  = qppe_pkg::LEAF_COUNT_DEF,
  parameter int COEFF_COUNT = qppe_pkg::COEFF_COUNT_DEF,
  parameter int MAX_DEGREE  = qppe_pkg::MAX_DEGREE_DEF,
  parameter int MAX_DEPTH   = qppe_pkg::MAX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         action,
  input  wire logic [9:0]         table_index,
  input  wire logic signed [7:0]  node_code,
  input  wire logic [6:0]         child_base,
  input  wire logic [2:0]         leaf_degree,
  input  wire logic [9:0]         coeff_base,
  input  wire logic signed [31:0] coeff_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value,
  output logic [6:0]              leaf_number,
  output logic [1:0]              status
);

  qppe_pkg::dp_cmd_t   cmd;
  qppe_pkg::dp_flags_t flags;

  qppe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  qppe_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .LEAF_COUNT  (LEAF_COUNT),
    .COEFF_COUNT (COEFF_COUNT),
    .MAX_DEGREE  (MAX_DEGREE),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .table_index (table_index),
    .node_code   (node_code),
    .child_base  (child_base),
    .leaf_degree (leaf_degree),
    .coeff_base  (coeff_base),
    .coeff_value (coeff_value),
    .point_x     (point_x),
    .point_y     (point_y),
    .cmd         (cmd),
    .flags       (flags),
    .value       (value),
    .leaf_number (leaf_number),
    .status      (status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/qppe_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree polynomial evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module qppe_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [2:0]         action,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] value,
  input wire logic [6:0]         leaf_number,
  input wire logic [1:0]         status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result item was dropped.");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == qppe_pkg::ACT_EVAL |=> in_stall)
    else $error("Input not stalled after an evaluate item.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("Undefined status code on a result item.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != qppe_pkg::ST_OK |-> value == '0 && leaf_number == '0)
    else $error("Error result item carries a nonzero value or leaf.");

endmodule

bind quadtree_piecewise_poly_eval qppe_checker u_qppe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .value       (value),
  .leaf_number (leaf_number),
  .status      (status)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadtree polynomial evaluator testbench
// Fills the tree tables, then sends directed and random load, evaluate and
// unused-action items under random input idling and output stalls. Each evaluate
// result is checked against a predictor that walks the same tree in Q16.16.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NODES = 128;
  localparam int LEAVES = 128;
  localparam int COEFFS = 1024;
  localparam int COEF_FILL = 160;
  localparam int COEF_TOP = 992;
  localparam int DEPTH_LIMIT = 16;
  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [2:0] act;
    logic [9:0] idx;
    logic signed [7:0] code;
    logic [6:0] cbase;
    logic [2:0] deg;
    logic [9:0] kbase;
    logic signed [31:0] coef;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } item_t;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0] leaf;
    logic [1:0] status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [9:0] table_index = '0;
  logic signed [7:0] node_code = '0;
  logic [6:0] child_base = '0;
  logic [2:0] leaf_degree = '0;
  logic [9:0] coeff_base = '0;
  logic signed [31:0] coeff_value = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic [6:0] leaf_number;
  logic [1:0] status;

  // Predictor state.
  longint rect_xl, rect_xh, rect_yl, rect_yh;
  longint node_tab[NODES];
  int child_tab[NODES];
  int deg_tab[LEAVES];
  int kbase_tab[LEAVES];
  longint coef_tab[COEFFS];

  eval_result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  quadtree_piecewise_poly_eval u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .table_index(table_index),
    .node_code(node_code), .child_base(child_base), .leaf_degree(leaf_degree),
    .coeff_base(coeff_base), .coeff_value(coeff_value), .point_x(point_x),
    .point_y(point_y), .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .leaf_number(leaf_number), .status(status)
  );

  always #5 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic eval_result_t evaluate(longint px, longint py);
    eval_result_t r;
    longint xl, xh, yl, yh, mx, my, code, acc;
    longint row[9];
    int lvl, son, internal, node, leaf, deg, addr, cnt;
    logic [1:0] st;
    xl = rect_xl; xh = rect_xh; yl = rect_yl; yh = rect_yh;
    code = node_tab[0];
    lvl = 0;
    st = qppe_pkg::ST_OK;
    acc = 0;
    leaf = 0;
    while (code < 0 && st == qppe_pkg::ST_OK) begin
      internal = int'(-code);
      if (lvl >= DEPTH_LIMIT) st = qppe_pkg::ST_DEPTH;
      else if (internal >= NODES) st = qppe_pkg::ST_INDEX;
      else begin
        mx = (xl + xh) >>> 1;
        my = (yl + yh) >>> 1;
        son = 0;
        if (px > mx) begin son += 1; xl = mx; end else xh = mx;
        if (py > my) begin son += 2; yl = my; end else yh = my;
        node = child_tab[internal] + son;
        if (node >= NODES) st = qppe_pkg::ST_INDEX;
        else begin
          code = node_tab[node];
          lvl++;
        end
      end
    end
    if (st == qppe_pkg::ST_OK) begin
      leaf = int'(code);
      deg = deg_tab[leaf];
      addr = kbase_tab[leaf];
      cnt = (deg + 1) * (deg + 2) / 2;
      if (leaf >= LEAVES || addr + cnt > COEFFS) st = qppe_pkg::ST_INDEX;
      else begin
        acc = sat32(coef_tab[addr]);
        addr++;
        row[0] = 64'sd65536;
        for (int k = 1; k <= deg; k++) begin
          for (int n = k; n >= 1; n--) row[n] = qmul(row[n - 1], py);
          row[0] = qmul(row[0], px);
          for (int n = 0; n <= k; n++) begin
            acc = sat32(acc + ((coef_tab[addr] * row[n]) >>> 16));
            addr++;
          end
        end
      end
    end
    r.status = st;
    r.value = (st == qppe_pkg::ST_OK) ? 32'(acc) : '0;
    r.leaf = (st == qppe_pkg::ST_OK) ? 7'(leaf) : '0;
    return r;
  endfunction

  function automatic void predict(item_t it);
    case (it.act)
      qppe_pkg::ACT_NODE: if (it.idx < NODES) node_tab[it.idx] = it.code;
      qppe_pkg::ACT_CHILD: if (it.idx < NODES) child_tab[it.idx] = it.cbase;
      qppe_pkg::ACT_LEAF: if (it.idx < LEAVES) begin
        deg_tab[it.idx] = it.deg;
        kbase_tab[it.idx] = it.kbase;
      end
      qppe_pkg::ACT_COEF: if (it.idx < COEFFS) coef_tab[it.idx] = it.coef;
      qppe_pkg::ACT_EVAL: pending_results.push_back(evaluate(it.px, it.py));
      default: ;
    endcase
  endfunction

  task automatic send(item_t it);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    action = it.act; table_index = it.idx; node_code = it.code; child_base = it.cbase;
    leaf_degree = it.deg; coeff_base = it.kbase; coeff_value = it.coef;
    point_x = it.px; point_y = it.py;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict(it);
    @(negedge clk);
  endtask

  function automatic item_t blank(logic [2:0] act, int idx);
    item_t it;
    it.act = act; it.idx = 10'(idx);
    it.code = 8'($urandom); it.cbase = 7'($urandom); it.deg = 3'($urandom);
    it.kbase = 10'($urandom); it.coef = $urandom; it.px = $urandom; it.py = $urandom;
    return it;
  endfunction

  task automatic load_node(int idx, int code);
    item_t it = blank(qppe_pkg::ACT_NODE, idx);
    it.code = 8'(code);
    send(it);
  endtask

  task automatic load_child(int idx, int cb);
    item_t it = blank(qppe_pkg::ACT_CHILD, idx);
    it.cbase = 7'(cb);
    send(it);
  endtask

  task automatic load_leaf(int idx, int deg, int kb);
    item_t it = blank(qppe_pkg::ACT_LEAF, idx);
    it.deg = 3'(deg); it.kbase = 10'(kb);
    send(it);
  endtask

  task automatic load_coef(int idx, logic [31:0] c);
    item_t it = blank(qppe_pkg::ACT_COEF, idx);
    it.coef = c;
    send(it);
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y);
    item_t it = blank(qppe_pkg::ACT_EVAL, 0);
    it.px = x; it.py = y;
    send(it);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom) >>> $urandom_range(8, 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom) >>> 14);
    endcase
  endfunction

  function automatic int rand_node_code();
    int r = $urandom_range(99);
    if (r < 2) return -128;
    if (r < 55) return -int'($urandom_range(1, 127));
    return $urandom_range(0, 127);
  endfunction

  // Leaf bases point either into the low coefficient block or into the top one.
  function automatic int rand_kbase();
    return ($urandom_range(9) < 8) ? $urandom_range(0, COEF_FILL - 36)
                                   : $urandom_range(COEF_TOP, COEFFS - 1);
  endfunction

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(qppe_pkg::reg_t r, logic [31:0] d);
    cfg_we = 1'b1; cfg_index = r; cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (r)
      qppe_pkg::REG_X_LOW: rect_xl = longint'($signed(d));
      qppe_pkg::REG_X_HIGH: rect_xh = longint'($signed(d));
      qppe_pkg::REG_Y_LOW: rect_yl = longint'($signed(d));
      default: rect_yh = longint'($signed(d));
    endcase
  endtask

  task automatic test_fill_tables();
    for (int i = 0; i < NODES; i++) load_node(i, i == 0 ? -1 : rand_node_code());
    for (int i = 0; i < NODES; i++) load_child(i, $urandom_range(1, 127));
    for (int i = 0; i < LEAVES; i++) load_leaf(i, $urandom_range(0, 7), rand_kbase());
    for (int i = 0; i < COEF_FILL; i++) load_coef(i, rand_coef());
    for (int i = COEF_TOP; i < COEFFS; i++) load_coef(i, rand_coef());
  endtask

  task automatic test_directed();
    load_node(0, 5);
    load_leaf(5, 7, 0);
    load_coef(0, 32'h7fffffff);
    eval_point(32'h7fffffff, 32'h80000000);
    eval_point(32'h80000000, 32'h7fffffff);
    load_leaf(5, 0, 1023);
    eval_point(0, 0);
    load_leaf(5, 2, 1020);
    eval_point(0, 0);
    load_node(0, -128);
    eval_point(0, 0);
    load_node(0, -1);
    load_child(1, 127);
    eval_point(32'h00010000, 32'h00010000);
    eval_point(0, 0);
    load_child(1, 0);
    eval_point(0, 0);
    load_node(1023, 3);
    load_coef(1023, 32'hffff0000);
    begin
      item_t it = blank(3'd5, 0);
      send(it);
      it.act = 3'd7;
      send(it);
    end
    load_child(1, 4);
    eval_point(1, -1);
  endtask

  task automatic random_item(int eval_pct);
    int r = $urandom_range(99);
    if (r < eval_pct) eval_point(rand_coord(), rand_coord());
    else if (r < eval_pct + 6) load_node($urandom_range(1, 1023), rand_node_code());
    else if (r < eval_pct + 12) load_child($urandom_range(0, 1023), $urandom_range(0, 127));
    else if (r < eval_pct + 18) load_leaf($urandom_range(0, 1023), $urandom_range(0, 7),
                                          rand_kbase());
    else if (r < 97) load_coef($urandom_range(0, 1023), rand_coef());
    else begin
      item_t it = blank(3'($urandom_range(5, 7)), $urandom_range(0, 1023));
      send(it);
    end
  endtask

  task automatic test_config();
    logic [31:0] sets[4][4] = '{
      '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
      '{32'h00040000, 32'hfffc0000, 32'h00000000, 32'h00000100},
      '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000},
      '{32'hffff0000, 32'h00010000, 32'hffff0000, 32'h00010000}};
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      for (int r = 0; r < 4; r++) write_reg(qppe_pkg::reg_t'(r), sets[s][r]);
      repeat (40) random_item(70);
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 150; i++) begin
      calm = (i >= 60 && i < 100);
      random_item(65);
    end
    calm = 1'b0;
  endtask

  task automatic test_pressure();
    wait_idle();
    hold_cycles = 600;
    repeat (20) eval_point(rand_coord(), rand_coord());
    wait_idle();
    repeat (20) random_item(60);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin
    eval_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: value %h leaf %0d status %0d",
                 $time, value, leaf_number, status);
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value || leaf_number !== exp_r.leaf || status !== exp_r.status) begin
          errors++;
          $display("%0t: expected value %h leaf %0d status %0d, got %h %0d %0d", $time,
                   exp_r.value, exp_r.leaf, exp_r.status, value, leaf_number, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT + DRAIN_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rect_xl = -65536; rect_xh = 65536; rect_yl = -65536; rect_yh = 65536;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_fill_tables();
    test_directed();
    test_config();
    test_random();
    test_pressure();
    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
